// ===== rtl/core/dltq_pkg.sv =====
package dltq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;

    localparam logic [1:0] REQ_SCHEDULE   = 2'd0;
    localparam logic [1:0] REQ_UNSCHEDULE = 2'd1;
    localparam logic [1:0] REQ_TICK       = 2'd2;
    localparam logic [1:0] REQ_BAD        = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EXPIRED   = 3'd3;
    localparam logic [2:0] ST_NONE      = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] id;
        logic [7:0]  owner;
        logic [30:0] ivl;
    } t_req;

endpackage

// ===== rtl/core/dltq_front.sv =====
module dltq_front import dltq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_req       i_req,
    output logic       busy,
    output logic       o_qvalid,
    output t_req       o_qreq,
    input  logic       i_qpop
);

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign busy     = (r_cnt == 2'd2);
    assign o_qvalid = (r_cnt != 2'd0);
    assign o_qreq   = r_q[r_rp];

    // Undefined request codes are taken and dropped here.
    assign w_push = start && !busy && (i_req.op != REQ_BAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= i_req;
                r_wp      <= ~r_wp;
            end
            if (i_qpop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_qpop};
        end
    end

endmodule

// ===== rtl/core/dltq_back.sv =====
module dltq_back import dltq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_tick_interval,
    input  logic        i_qvalid,
    input  t_req        i_qreq,
    output logic        o_qpop,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_expired_id,
    output logic [7:0]  o_expired_owner,
    output logic        o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [31:0] delta;
        logic [15:0] id;
        logic [7:0]  owner;
    } t_entry;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCH_RD = 4'd1;
    localparam logic [3:0] S_SCH_EV = 4'd2;
    localparam logic [3:0] S_SHF_RD = 4'd3;
    localparam logic [3:0] S_SHF_EV = 4'd4;
    localparam logic [3:0] S_SCH_WR = 4'd5;
    localparam logic [3:0] S_UNS_RD = 4'd6;
    localparam logic [3:0] S_UNS_EV = 4'd7;
    localparam logic [3:0] S_TCK_RD = 4'd8;
    localparam logic [3:0] S_TCK_EV = 4'd9;
    localparam logic [3:0] S_CPY_RD = 4'd10;
    localparam logic [3:0] S_CPY_EV = 4'd11;

    t_entry          r_mem [DEPTH];
    t_entry          r_rdata;
    logic [3:0]      r_state;
    t_req            r_req;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_rd;
    logic [CW-1:0]   r_wr;
    logic [31:0]     r_acc;
    logic            r_found;
    logic [NW-1:0]   r_n;
    logic            r_pend;
    logic [15:0]     r_pend_id;
    logic [7:0]      r_pend_owner;
    logic            r_ovalid;
    logic [2:0]      r_ostatus;
    logic [15:0]     r_oid;
    logic [7:0]      r_oown;
    logic            r_olast;

    logic [32:0]     w_sum;
    logic [31:0]     w_nd;
    logic            w_match;
    logic            w_expire;

    assign o_qpop          = (r_state == S_IDLE) && i_qvalid;
    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_expired_id    = r_oid;
    assign o_expired_owner = r_oown;
    assign o_last          = r_olast;

    assign w_sum    = {1'b0, r_acc} + {1'b0, r_rdata.delta};
    assign w_nd     = {1'b0, r_req.ivl} - r_acc;
    assign w_match  = (r_rdata.id == r_req.id) && (r_rdata.owner == r_req.owner);
    // r_acc holds the tick budget that is left during a tick.
    assign w_expire = (r_rdata.delta <= r_acc) && (r_n < NW'(MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_qvalid) begin
                        r_req   <= i_qreq;
                        r_rd    <= '0;
                        r_wr    <= '0;
                        r_acc   <= '0;
                        r_found <= 1'b0;
                        r_n     <= '0;
                        r_pend  <= 1'b0;
                        unique case (i_qreq.op)
                            REQ_SCHEDULE: begin
                                if (r_count >= CW'(DEPTH)) begin
                                    r_ovalid  <= 1'b1;
                                    r_ostatus <= ST_FULL;
                                    r_oid     <= '0;
                                    r_oown    <= '0;
                                    r_olast   <= 1'b1;
                                end else begin
                                    r_state <= S_SCH_RD;
                                end
                            end
                            REQ_UNSCHEDULE: r_state <= S_UNS_RD;
                            default: begin
                                r_acc   <= {16'd0, i_tick_interval};
                                r_state <= S_TCK_RD;
                            end
                        endcase
                    end
                end
                S_SCH_RD: begin
                    if (r_rd == r_count) begin
                        r_wr    <= r_count;
                        r_state <= S_SHF_RD;
                    end else begin
                        r_rdata <= r_mem[r_rd[AW-1:0]];
                        r_state <= S_SCH_EV;
                    end
                end
                S_SCH_EV: begin
                    if ({2'b0, r_req.ivl} >= w_sum) begin
                        r_acc   <= w_sum[31:0];
                        r_rd    <= r_rd + 1'b1;
                        r_state <= S_SCH_RD;
                    end else begin
                        r_wr    <= r_count;
                        r_state <= S_SHF_RD;
                    end
                end
                // Shift entries up from the tail down to the insert point.
                S_SHF_RD: begin
                    if (r_wr == r_rd) begin
                        r_state <= S_SCH_WR;
                    end else begin
                        r_rdata <= r_mem[AW'(r_wr - 1'b1)];
                        r_state <= S_SHF_EV;
                    end
                end
                S_SHF_EV: begin
                    if ((r_wr - 1'b1) == r_rd) begin
                        r_mem[r_wr[AW-1:0]] <= '{r_rdata.delta - w_nd, r_rdata.id,
                                                 r_rdata.owner};
                    end else begin
                        r_mem[r_wr[AW-1:0]] <= r_rdata;
                    end
                    r_wr    <= r_wr - 1'b1;
                    r_state <= S_SHF_RD;
                end
                S_SCH_WR: begin
                    r_mem[r_rd[AW-1:0]] <= '{w_nd, r_req.id, r_req.owner};
                    r_count   <= r_count + 1'b1;
                    r_ovalid  <= 1'b1;
                    r_ostatus <= ST_OK;
                    r_oid     <= '0;
                    r_oown    <= '0;
                    r_olast   <= 1'b1;
                    r_state   <= S_IDLE;
                end
                // Compacting pass: removed deltas are carried to the next kept entry.
                S_UNS_RD: begin
                    if (r_rd == r_count) begin
                        r_count   <= r_wr;
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_found ? ST_OK : ST_NOT_FOUND;
                        r_oid     <= '0;
                        r_oown    <= '0;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_rdata <= r_mem[r_rd[AW-1:0]];
                        r_state <= S_UNS_EV;
                    end
                end
                S_UNS_EV: begin
                    if (w_match) begin
                        r_acc   <= w_sum[31:0];
                        r_found <= 1'b1;
                    end else begin
                        r_mem[r_wr[AW-1:0]] <= '{w_sum[31:0], r_rdata.id, r_rdata.owner};
                        r_acc <= '0;
                        r_wr  <= r_wr + 1'b1;
                    end
                    r_rd    <= r_rd + 1'b1;
                    r_state <= S_UNS_RD;
                end
                // An expired entry is held back one step so that its last flag is known.
                S_TCK_RD: begin
                    if (r_rd == r_count) begin
                        r_count   <= '0;
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_pend ? ST_EXPIRED : ST_NONE;
                        r_oid     <= r_pend ? r_pend_id : 16'd0;
                        r_oown    <= r_pend ? r_pend_owner : 8'd0;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_rdata <= r_mem[r_rd[AW-1:0]];
                        r_state <= S_TCK_EV;
                    end
                end
                S_TCK_EV: begin
                    r_ovalid  <= r_pend || !w_expire;
                    r_ostatus <= r_pend ? ST_EXPIRED : ST_NONE;
                    r_oid     <= r_pend ? r_pend_id : 16'd0;
                    r_oown    <= r_pend ? r_pend_owner : 8'd0;
                    r_olast   <= !w_expire;
                    if (w_expire) begin
                        r_pend       <= 1'b1;
                        r_pend_id    <= r_rdata.id;
                        r_pend_owner <= r_rdata.owner;
                        r_acc        <= r_acc - r_rdata.delta;
                        r_n          <= r_n + 1'b1;
                        r_rd         <= r_rd + 1'b1;
                        r_state      <= S_TCK_RD;
                    end else begin
                        r_pend <= 1'b0;
                        r_mem[0] <= '{(r_rdata.delta > r_acc) ?
                                      r_rdata.delta - r_acc : 32'd0,
                                      r_rdata.id, r_rdata.owner};
                        r_wr <= CW'(1);
                        r_rd <= r_rd + 1'b1;
                        if (r_n == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_CPY_RD;
                        end
                    end
                end
                S_CPY_RD: begin
                    if (r_rd == r_count) begin
                        r_count <= r_wr;
                        r_state <= S_IDLE;
                    end else begin
                        r_rdata <= r_mem[r_rd[AW-1:0]];
                        r_state <= S_CPY_EV;
                    end
                end
                S_CPY_EV: begin
                    r_mem[r_wr[AW-1:0]] <= r_rdata;
                    r_wr    <= r_wr + 1'b1;
                    r_rd    <= r_rd + 1'b1;
                    r_state <= S_CPY_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/delta_list_timeout_queue.sv =====
// Delta-list timeout queue.
// Requests enter on start while busy is low: schedule, unschedule or tick,
// with i_timeout_id, i_owner_id and i_interval. Request code 3 is dropped.
// A two-item queue sits between the request front and the list engine, so
// busy rises only when two requests are waiting behind the one in work.
// Results appear on o_status, o_expired_id, o_expired_owner and o_last for
// one cycle each, marked by o_valid; the receiver cannot stall them.
// Schedule and unschedule give one result, a tick one per expired entry
// (at most 16) or a single none-expired result; o_last marks the final one.
// The list lives in a single-port memory with registered reads, so every
// walk visits each entry in a read state and then an evaluate state. A
// schedule on a full list is answered from the idle state with ST_FULL.
// i_cfg_we writes the tick interval from i_cfg_wdata; reset sets it to 1.
// Synchronous reset empties the list and the queue; no clearing pass runs.
module delta_list_timeout_queue import dltq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_timeout_id,
    input  logic [7:0]  i_owner_id,
    input  logic [30:0] i_interval,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_expired_id,
    output logic [7:0]  o_expired_owner,
    output logic        o_last
);

    logic [15:0] r_tick_interval;
    t_req        w_req;
    t_req        w_qreq;
    logic        w_qvalid;
    logic        w_qpop;

    assign w_req = '{i_req_type, i_timeout_id, i_owner_id, i_interval};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_interval <= 16'd1;
        end else if (i_cfg_we) begin
            r_tick_interval <= i_cfg_wdata;
        end
    end

    dltq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (w_req),
        .busy     (busy),
        .o_qvalid (w_qvalid),
        .o_qreq   (w_qreq),
        .i_qpop   (w_qpop)
    );

    dltq_back #(.DEPTH(DEPTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick_interval (r_tick_interval),
        .i_qvalid        (w_qvalid),
        .i_qreq          (w_qreq),
        .o_qpop          (w_qpop),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_expired_id    (o_expired_id),
        .o_expired_owner (o_expired_owner),
        .o_last          (o_last)
    );

endmodule
